### rtl/position_cascade_pid_loop_assert.svh
// Assertion macros used by the top level of the position cascade PID loop.
`ifndef POSITION_CASCADE_PID_LOOP_ASSERT_SVH
`define POSITION_CASCADE_PID_LOOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PCPID_ASSERT(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("pcpid assertion failed");
`define PCPID_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("pcpid assertion failed");
`else
`define PCPID_ASSERT(name, cond)
`define PCPID_ASSERT_NEXT(name, pre, post)
`endif
`endif

### rtl/pcpid_pkg.sv
// Shared types, constants and helper functions of the cascade PID loop.
package pcpid_pkg;

    // Number format and fixed limits.
    localparam int FRAC_BITS  = 16;
    localparam int GATE_MM    = 100;
    localparam int US_PER_S   = 1000000;

    // Arithmetic unit widths.
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 40;
    localparam int MUL_SPLIT  = MUL_B_W / 2;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int GAIN_FRAC  = 32;
    localparam int DIVIDEND_W = 58;
    localparam int DIVISOR_W  = 25;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam int ACC_W      = 48;

    localparam logic signed [31:0] SAT_HI   = {1'b0, {31{1'b1}}};
    localparam logic signed [31:0] SAT_LO   = {1'b1, {31{1'b0}}};
    localparam logic signed [31:0] ILIM     = 32'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [31:0] NEG_ILIM = -ILIM;
    localparam logic signed [31:0] OLIM     = 32'sd3 <<< FRAC_BITS;
    localparam logic signed [31:0] NEG_OLIM = -OLIM;

    // Register reset values.
    localparam logic [23:0] RST_FILTER_TIME = 24'd20000;
    localparam logic [39:0] RST_OUTER_P     = 40'd1589138;
    localparam logic [39:0] RST_OUTER_I_X   = 40'd2147;
    localparam logic [39:0] RST_OUTER_I_Y   = 40'd1288;
    localparam logic [39:0] RST_OUTER_D     = 40'd42950;
    localparam logic [39:0] RST_FORWARD     = 40'd150323855360;
    localparam logic [39:0] RST_INNER_P     = 40'd120259084288;
    localparam logic [39:0] RST_DAMPING     = 40'd987842478;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_FILTER_TIME,
        CFG_OUTER_P,
        CFG_OUTER_I_X,
        CFG_OUTER_I_Y,
        CFG_OUTER_D,
        CFG_FORWARD,
        CFG_INNER_P,
        CFG_DAMPING
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] position_x;
        logic signed [31:0] velocity_x;
        logic signed [31:0] target_y;
        logic signed [31:0] position_y;
        logic signed [31:0] velocity_y;
        logic        [15:0] altitude_mm;
        logic        [23:0] elapsed_us;
    } t_in;

    typedef struct packed {
        logic signed [31:0] drive_x;
        logic signed [31:0] damp_x;
        logic signed [31:0] drive_y;
        logic signed [31:0] damp_y;
        logic               updated;
    } t_out;

    // Datapath micro-operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERR,
        OP_RATE_DIV,
        OP_RATE_MUL,
        OP_FILT_DIV,
        OP_FILT_UPD,
        OP_INTEG,
        OP_PSUM,
        OP_OUTER,
        OP_FWD,
        OP_DRIVE,
        OP_DAMP,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic axis;
    } t_cmd;

    typedef struct packed {
        logic unit_done;
        logic gate_open;
        logic out_free;
    } t_stat;

    // Clamp a wide signed value into a 32-bit range.
    function automatic logic signed [31:0] f_clip(input logic signed [63:0] v,
                                                  input logic signed [31:0] lo,
                                                  input logic signed [31:0] hi);
        logic signed [31:0] res;
        if (v > hi) begin
            res = hi;
        end else if (v < lo) begin
            res = lo;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

### rtl/pcpid_mul.sv
// Two-pass signed by unsigned multiplier, split into two partial products.
module pcpid_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [pcpid_pkg::MUL_A_W-1:0]  i_a,
    input  logic        [pcpid_pkg::MUL_B_W-1:0]  i_b,
    output logic                                  o_done,
    output logic signed [pcpid_pkg::PROD_W-1:0]   o_prod
);
    import pcpid_pkg::*;

    logic signed [MUL_A_W-1:0]         r_a;
    logic        [MUL_B_W-1:0]         r_b;
    logic signed [MUL_A_W+MUL_SPLIT:0] r_lo;
    logic signed [PROD_W-1:0]          r_prod;
    logic                              r_ph1;
    logic                              r_ph2;
    logic                              r_done;

    logic signed [MUL_A_W+MUL_SPLIT:0] lo_c;
    logic signed [PROD_W-1:0]          hi_c;

    // Low and high halves of the gain, each a narrow product.
    assign lo_c = r_a * $signed({1'b0, r_b[MUL_SPLIT-1:0]});
    assign hi_c = r_a * $signed({1'b0, r_b[MUL_B_W-1:MUL_SPLIT]});

    // Phase control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph1  <= 1'b0;
            r_ph2  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_ph1  <= i_start;
            r_ph2  <= r_ph1;
            r_done <= r_ph2;
        end
    end

    // Operands and partial products.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_ph1) begin
            r_lo <= lo_c;
        end
        if (r_ph2) begin
            r_prod <= (hi_c <<< MUL_SPLIT) + PROD_W'(r_lo);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

### rtl/pcpid_div.sv
// Restoring divider, one quotient bit per cycle, quotient truncated toward zero.
module pcpid_div (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic signed [pcpid_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic        [pcpid_pkg::DIVISOR_W-1:0]  i_divisor,
    output logic                                    o_done,
    output logic signed [pcpid_pkg::DIVIDEND_W-1:0] o_quo
);
    import pcpid_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_neg;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_q;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVIDEND_W-1:0] mag_c;
    logic [DIVISOR_W:0]    shift_c;
    logic                  ge_c;
    logic [DIVISOR_W:0]    diff_c;

    assign mag_c   = i_dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-i_dividend)
                                              : DIVIDEND_W'(i_dividend);
    assign shift_c = {r_rem, r_q[DIVIDEND_W-1]};
    assign ge_c    = (shift_c >= {1'b0, r_div});
    assign diff_c  = shift_c - {1'b0, r_div};

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_W'(DIVIDEND_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Magnitude division on the shifting remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DIVIDEND_W-1];
            r_rem <= '0;
            r_q   <= mag_c;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge_c ? diff_c[DIVISOR_W-1:0] : shift_c[DIVISOR_W-1:0];
            r_q   <= {r_q[DIVIDEND_W-2:0], ge_c};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

### rtl/pcpid_datapath.sv
// Datapath: registers, loop state, shared multiplier and divider, result register.
module pcpid_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [39:0]       i_cfg_data,
    input  pcpid_pkg::t_in    i_in_data,
    input  pcpid_pkg::t_cmd   i_cmd,
    output pcpid_pkg::t_stat  o_stat,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output pcpid_pkg::t_out   o_out_data
);
    import pcpid_pkg::*;

    // Configuration.
    logic [23:0] r_ftime;
    logic [39:0] r_kp;
    logic [39:0] r_ki [2];
    logic [39:0] r_kd;
    logic [39:0] r_kf;
    logic [39:0] r_kv;
    logic [39:0] r_kdm;

    // Loop state per axis and held results.
    logic signed [31:0] r_last  [2];
    logic signed [31:0] r_filt  [2];
    logic signed [31:0] r_integ [2];
    logic signed [31:0] r_held  [4];

    // Working registers.
    t_in                r_in;
    logic signed [31:0] r_e;
    logic signed [31:0] r_u;
    logic signed [ACC_W-1:0] r_acc;
    logic               r_out_valid;
    t_out               r_out;

    logic                         ax;
    logic [23:0]                  dt_c;
    logic [DIVISOR_W-1:0]         den_c;
    logic signed [31:0]           tgt_c;
    logic signed [31:0]           pos_c;
    logic signed [31:0]           vel_c;
    logic signed [32:0]           diff_c;
    logic signed [31:0]           e_c;
    logic signed [31:0]           raw_c;
    logic signed [31:0]           u_c;
    logic signed [31:0]           d_c;
    logic signed [PROD_W-GAIN_FRAC-1:0] g_c;
    logic                         gate_c;

    logic                         mul_start;
    logic signed [MUL_A_W-1:0]    mul_a;
    logic        [MUL_B_W-1:0]    mul_b;
    logic                         mul_done;
    logic signed [PROD_W-1:0]     mul_prod;
    logic                         div_start;
    logic [DIVISOR_W-1:0]         div_divisor;
    logic                         div_done;
    logic signed [DIVIDEND_W-1:0] div_quo;

    assign ax     = i_cmd.axis;
    assign dt_c   = (r_in.elapsed_us == '0) ? 24'd1 : r_in.elapsed_us;
    assign den_c  = {1'b0, r_ftime} + {1'b0, dt_c};
    assign gate_c = (r_in.altitude_mm > 16'(GATE_MM));

    // Per-axis operand selection.
    assign tgt_c = ax ? r_in.target_y   : r_in.target_x;
    assign pos_c = ax ? r_in.position_y : r_in.position_x;
    assign vel_c = ax ? r_in.velocity_y : r_in.velocity_x;

    // Step results formed from the unit outputs.
    assign diff_c = 33'(tgt_c) - 33'(pos_c);
    assign e_c    = f_clip(64'(diff_c), SAT_LO, SAT_HI);
    assign g_c    = $signed(mul_prod[PROD_W-1:GAIN_FRAC]);
    assign raw_c  = f_clip(64'(div_quo), SAT_LO, SAT_HI);
    assign u_c    = f_clip(64'(r_acc) + 64'(g_c), NEG_OLIM, OLIM);
    assign d_c    = f_clip(64'(r_acc) + 64'(g_c), SAT_LO, SAT_HI);

    // Operand routing to the shared multiplier and divider.
    always_comb begin
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        div_divisor = {1'b0, dt_c};
        unique case (i_cmd.op)
            OP_ERR: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(e_c) - MUL_A_W'(r_last[ax]);
                mul_b     = MUL_B_W'(US_PER_S);
            end
            OP_RATE_DIV: begin
                div_start = 1'b1;
            end
            OP_RATE_MUL: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(raw_c) - MUL_A_W'(r_filt[ax]);
                mul_b     = MUL_B_W'(dt_c);
            end
            OP_FILT_DIV: begin
                div_start   = 1'b1;
                div_divisor = den_c;
            end
            OP_FILT_UPD: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(r_e);
                mul_b     = r_ki[ax];
            end
            OP_INTEG: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(r_e);
                mul_b     = r_kp;
            end
            OP_PSUM: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(r_filt[ax]);
                mul_b     = r_kd;
            end
            OP_OUTER: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(u_c);
                mul_b     = r_kf;
            end
            OP_FWD: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(r_u) - MUL_A_W'(vel_c);
                mul_b     = r_kv;
            end
            OP_DRIVE: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(d_c);
                mul_b     = r_kdm;
            end
            default: begin
            end
        endcase
    end

    pcpid_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    pcpid_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ($signed(mul_prod[DIVIDEND_W-1:0])),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ftime  <= RST_FILTER_TIME;
            r_kp     <= RST_OUTER_P;
            r_ki[0]  <= RST_OUTER_I_X;
            r_ki[1]  <= RST_OUTER_I_Y;
            r_kd     <= RST_OUTER_D;
            r_kf     <= RST_FORWARD;
            r_kv     <= RST_INNER_P;
            r_kdm    <= RST_DAMPING;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FILTER_TIME: r_ftime <= i_cfg_data[23:0];
                CFG_OUTER_P:     r_kp    <= i_cfg_data;
                CFG_OUTER_I_X:   r_ki[0] <= i_cfg_data;
                CFG_OUTER_I_Y:   r_ki[1] <= i_cfg_data;
                CFG_OUTER_D:     r_kd    <= i_cfg_data;
                CFG_FORWARD:     r_kf    <= i_cfg_data;
                CFG_INNER_P:     r_kv    <= i_cfg_data;
                CFG_DAMPING:     r_kdm   <= i_cfg_data;
            endcase
        end
    end

    // Loop state and held outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_last[k]  <= '0;
                r_filt[k]  <= '0;
                r_integ[k] <= '0;
            end
            for (int k = 0; k < 4; k++) begin
                r_held[k] <= '0;
            end
        end else begin
            unique case (i_cmd.op)
                OP_FILT_UPD: begin
                    r_filt[ax] <= f_clip(64'(r_filt[ax]) + 64'(div_quo), SAT_LO, SAT_HI);
                    r_last[ax] <= r_e;
                end
                OP_INTEG: begin
                    r_integ[ax] <= f_clip(64'(r_integ[ax]) + 64'(g_c), NEG_ILIM, ILIM);
                end
                OP_DRIVE: begin
                    r_held[{ax, 1'b0}] <= d_c;
                end
                OP_DAMP: begin
                    r_held[{ax, 1'b1}] <= f_clip(64'(g_c), SAT_LO, SAT_HI);
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers of the current tick.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD:  r_in  <= i_in_data;
            OP_ERR:   r_e   <= e_c;
            OP_PSUM:  r_acc <= ACC_W'(g_c) + ACC_W'(r_integ[ax]);
            OP_OUTER: r_u   <= u_c;
            OP_FWD:   r_acc <= ACC_W'(g_c);
            default: begin
            end
        endcase
    end

    // Result register; it holds while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_out.drive_x <= r_held[0];
            r_out.damp_x  <= r_held[1];
            r_out.drive_y <= r_held[2];
            r_out.damp_y  <= r_held[3];
            r_out.updated <= gate_c;
        end
    end

    assign o_stat.unit_done = mul_done | div_done;
    assign o_stat.gate_open = gate_c;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

endmodule

### rtl/pcpid_ctrl.sv
// Controller: sequences the per-axis steps through the shared units.
module pcpid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pcpid_pkg::t_stat  i_stat,
    output pcpid_pkg::t_cmd   o_cmd
);
    import pcpid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GATE,
        S_RUN,
        S_WAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_op    r_step;
    logic   r_axis;

    // Order of the steps of one axis.
    function automatic t_op f_next(input t_op op);
        t_op res;
        unique case (op)
            OP_ERR:      res = OP_RATE_DIV;
            OP_RATE_DIV: res = OP_RATE_MUL;
            OP_RATE_MUL: res = OP_FILT_DIV;
            OP_FILT_DIV: res = OP_FILT_UPD;
            OP_FILT_UPD: res = OP_INTEG;
            OP_INTEG:    res = OP_PSUM;
            OP_PSUM:     res = OP_OUTER;
            OP_OUTER:    res = OP_FWD;
            OP_FWD:      res = OP_DRIVE;
            OP_DRIVE:    res = OP_DAMP;
            default:     res = OP_DAMP;
        endcase
        return res;
    endfunction

    // State, step and axis.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= OP_ERR;
            r_axis  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_GATE;
                    end
                end
                S_GATE: begin
                    r_step <= OP_ERR;
                    r_axis <= 1'b0;
                    r_state <= i_stat.gate_open ? S_RUN : S_OUT;
                end
                S_RUN: begin
                    if (r_step == OP_DAMP) begin
                        if (!r_axis) begin
                            r_axis <= 1'b1;
                            r_step <= OP_ERR;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_step  <= f_next(r_step);
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (i_stat.unit_done) begin
                        r_state <= S_RUN;
                    end
                end
                S_OUT: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Command to the datapath.
    always_comb begin
        o_cmd.axis = r_axis;
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_RUN:   o_cmd.op = r_step;
            S_OUT:   o_cmd.op = i_stat.out_free ? OP_EMIT : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### rtl/position_cascade_pid_loop.sv
// Top level of the two-axis cascaded position PID loop.
// Usage:
// - The input channel (i_in_valid, o_in_stall, i_in_data) carries one tick: targets,
//   positions and velocities of both axes, altitude and elapsed microseconds.
// - The output channel (o_out_valid, i_out_stall, o_out_data) returns one result
//   per tick: drive and damping per axis plus the updated flag.
// - Registers are written through i_cfg_we, i_cfg_index and i_cfg_data while idle.
// - When the altitude is at or below 100 mm the held outputs are returned and no
//   loop state changes.
// - Otherwise each axis takes 8 multiplies and 2 divisions on the 58-step divider.
// - One tick is worked at a time; the next transfer is taken once the result is in
//   the output register, even while the receiver still stalls it.
// - A stalled result stays unchanged in the output register.
// - Synchronous reset restores register defaults, clears the loop state and held
//   outputs to zero and empties the output register.
module position_cascade_pid_loop (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  pcpid_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output pcpid_pkg::t_out  o_out_data,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [39:0]      i_cfg_data
);
    import pcpid_pkg::*;

`include "position_cascade_pid_loop_assert.svh"

    t_cmd  w_cmd;
    t_stat w_stat;

    pcpid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pcpid_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // A loaded tick goes to the gate check with nothing issued.
    `PCPID_ASSERT_NEXT(a_load_then_gate, w_cmd.op == OP_LOAD, o_in_stall && (w_cmd.op == OP_NONE))
    // An emitted result shows up and the block is ready again.
    `PCPID_ASSERT_NEXT(a_emit_shows_result, w_cmd.op == OP_EMIT, o_out_valid && !o_in_stall)
    // Datapath steps run only while input transfers are held off.
    `PCPID_ASSERT(a_steps_while_busy, (w_cmd.op == OP_NONE) || (w_cmd.op == OP_LOAD) || o_in_stall)

endmodule

### test/position_cascade_pid_loop_tb.sv
// Self-checking testbench of the two-axis cascaded position PID loop.
module position_cascade_pid_loop_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcpid_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [39:0] i_cfg_data;

    position_cascade_pid_loop u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the register file and the loop state.
    logic [23:0] filt_tc;
    logic [39:0] gain_reg [1:7];
    longint      prev_err [2];
    longint      rate_filt [2];
    longint      integ_acc [2];
    longint      held_out [4];

    t_out        pending_results [$];
    int          error_count;
    int          ticks_sent;
    int          ticks_open;
    int          results_seen;
    int          cfg_sets;
    bit          hold_request;
    bit          stall_enable;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint clip(input longint v, input longint lim);
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    // Exact floor(x * g / 2^32).
    function automatic longint gain_mul(input longint x, input logic [39:0] g);
        logic signed [127:0] xa;
        logic signed [127:0] ga;
        logic signed [127:0] prod;
        xa = x;
        ga = {88'd0, g};
        prod = (xa * ga) >>> 32;
        return longint'(prod[63:0]);
    endfunction

    // One axis of the controller; returns drive and damping, updates state.
    task automatic axis_update(input int a, input longint tgt, input longint pos,
                               input longint vel, input longint dt,
                               input logic [39:0] ki,
                               output longint drive, output longint damp);
        longint e;
        longint raw;
        longint den;
        longint u;
        e = sat32(tgt - pos);
        raw = sat32(((e - prev_err[a]) * 64'sd1000000) / dt);
        den = longint'(filt_tc) + dt;
        rate_filt[a] = sat32(rate_filt[a] + ((raw - rate_filt[a]) * dt) / den);
        prev_err[a] = e;
        integ_acc[a] = clip(integ_acc[a] + gain_mul(e, ki), 64'sd1 <<< (FRAC_BITS - 1));
        u = gain_mul(e, gain_reg[CFG_OUTER_P]) + integ_acc[a]
            + gain_mul(rate_filt[a], gain_reg[CFG_OUTER_D]);
        u = clip(u, 64'sd3 <<< FRAC_BITS);
        drive = sat32(gain_mul(u, gain_reg[CFG_FORWARD])
                      + gain_mul(u - vel, gain_reg[CFG_INNER_P]));
        damp = sat32(gain_mul(drive, gain_reg[CFG_DAMPING]));
    endtask

    // Works out the result of one tick.
    task automatic predict_tick(input t_in t, output t_out r);
        longint dt;
        longint d0;
        longint d1;
        dt = (t.elapsed_us == 0) ? 64'sd1 : longint'(t.elapsed_us);
        r.updated = (t.altitude_mm > GATE_MM);
        if (r.updated) begin
            axis_update(0, t.target_x, t.position_x, t.velocity_x, dt,
                        gain_reg[CFG_OUTER_I_X], d0, d1);
            held_out[0] = d0;
            held_out[1] = d1;
            axis_update(1, t.target_y, t.position_y, t.velocity_y, dt,
                        gain_reg[CFG_OUTER_I_Y], d0, d1);
            held_out[2] = d0;
            held_out[3] = d1;
            ticks_open++;
        end
        r.drive_x = held_out[0][31:0];
        r.damp_x  = held_out[1][31:0];
        r.drive_y = held_out[2][31:0];
        r.damp_y  = held_out[3][31:0];
    endtask

    // Offers one tick and waits for its transfer; valid stays high afterwards.
    task automatic send_tick(input t_in t);
        t_out r;
        i_in_valid <= 1'b1;
        i_in_data  <= t;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_tick(t, r);
        pending_results.push_back(r);
        ticks_sent++;
    endtask

    task automatic idle_input(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Waits until every expected result has arrived, then lets the block settle.
    task automatic drain;
        idle_input(1);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [39:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == CFG_FILTER_TIME) begin
            filt_tc = val[23:0];
        end else begin
            gain_reg[idx] = val;
        end
    endtask

    // Writes a whole register set, closing the write strobe at the end.
    task automatic load_config(input logic [23:0] tc, input logic [39:0] g [1:7]);
        write_reg(CFG_FILTER_TIME, {16'd0, tc});
        for (int k = 1; k < 8; k++) begin
            write_reg(t_cfg_idx'(k), g[k]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_sets++;
    endtask

    function automatic logic [31:0] rand32;
        return $urandom;
    endfunction

    // Random tick: mostly a small error around a moving position.
    function automatic t_in random_tick;
        t_in t;
        int sel;
        t.position_x = $signed(rand32()) >>> $urandom_range(0, 10);
        t.position_y = $signed(rand32()) >>> $urandom_range(0, 10);
        t.target_x   = t.position_x + ($signed(rand32()) >>> $urandom_range(8, 20));
        t.target_y   = t.position_y + ($signed(rand32()) >>> $urandom_range(8, 20));
        t.velocity_x = $signed(rand32()) >>> $urandom_range(10, 16);
        t.velocity_y = $signed(rand32()) >>> $urandom_range(10, 16);
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            t.target_x   = rand32();
            t.position_x = rand32();
            t.velocity_x = rand32();
            t.target_y   = rand32();
            t.position_y = rand32();
            t.velocity_y = rand32();
        end
        t.altitude_mm = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 120))
                                                   : 16'($urandom_range(101, 65535));
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            t.elapsed_us = 24'($urandom);
        end else if (sel == 1) begin
            t.elapsed_us = 24'($urandom_range(0, 3));
        end else begin
            t.elapsed_us = 24'($urandom_range(500, 30000));
        end
        return t;
    endfunction

    // Sends random ticks in bursts with random gaps.
    task automatic random_run(input int n);
        int burst;
        burst = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
            send_tick(random_tick());
            burst--;
            if (burst == 0) begin
                idle_input($urandom_range(1, 20));
                burst = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic test_directed;
        t_in t;
        logic [31:0] ext [4];
        ext = '{32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff};
        // Extremes of the signed fields, gate open.
        for (int k = 0; k < 8; k++) begin
            t.target_x   = ext[k % 4];
            t.position_x = ext[(k + 1) % 4];
            t.velocity_x = ext[(k + 2) % 4];
            t.target_y   = ext[(k + 3) % 4];
            t.position_y = ext[k % 4];
            t.velocity_y = ext[(k / 2) % 4];
            t.altitude_mm = 16'hffff;
            t.elapsed_us  = (k < 4) ? 24'hffffff : 24'd1;
            send_tick(t);
        end
        // Zero elapsed time and the gate edges at 100 and 101 mm.
        t.elapsed_us  = 24'd0;
        t.altitude_mm = 16'd101;
        send_tick(t);
        t.altitude_mm = 16'd100;
        send_tick(t);
        t.altitude_mm = 16'd0;
        t.elapsed_us  = 24'd1000;
        send_tick(t);
        t.altitude_mm = 16'd101;
        t.target_x    = 32'sd65536;
        t.position_x  = 32'sd0;
        t.target_y    = -32'sd65536;
        t.position_y  = 32'sd0;
        t.velocity_x  = 32'sd0;
        t.velocity_y  = 32'sd0;
        t.elapsed_us  = 24'd1000000;
        send_tick(t);
        t.elapsed_us  = 24'd1000;
        send_tick(t);
        drain();
    endtask

    task automatic test_config_sweep;
        logic [39:0] g [1:7];
        // All gains zero, filter time zero.
        for (int k = 1; k < 8; k++) g[k] = 40'd0;
        load_config(24'd0, g);
        random_run(100);
        drain();
        // All gains at maximum, filter time at its largest.
        for (int k = 1; k < 8; k++) g[k] = {40{1'b1}};
        load_config(24'hffffff, g);
        random_run(100);
        drain();
        // Random gains below 2^38, filter time of one.
        for (int k = 1; k < 8; k++) g[k] = 40'({$urandom, $urandom}) & 40'h3f_ffff_ffff;
        load_config(24'd1, g);
        random_run(150);
        drain();
        // Fully random values, then back to the reset defaults.
        for (int k = 1; k < 8; k++) g[k] = 40'({$urandom, $urandom});
        load_config(24'($urandom), g);
        random_run(150);
        drain();
        g = '{RST_OUTER_P, RST_OUTER_I_X, RST_OUTER_I_Y, RST_OUTER_D,
              RST_FORWARD, RST_INNER_P, RST_DAMPING};
        load_config(RST_FILTER_TIME, g);
    endtask

    task automatic test_backpressure;
        hold_request = 1'b1;
        for (int k = 0; k < 20; k++) begin
            send_tick(random_tick());
        end
        drain();
    endtask

    task automatic test_random;
        random_run(950);
        drain();
    endtask

    // Receiver stall pattern, with an occasional long hold-off on request.
    initial begin
        int hold_cnt;
        int mode;
        i_out_stall <= 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            for (int k = 0; k < 150; k++) begin
                @(posedge i_clk);
                if (hold_request) begin
                    hold_request = 1'b0;
                    hold_cnt = 2000;
                end
                if (hold_cnt > 0) begin
                    hold_cnt--;
                    i_out_stall <= 1'b1;
                end else if (!stall_enable || mode == 0) begin
                    i_out_stall <= 1'b0;
                end else begin
                    i_out_stall <= ($urandom_range(0, 99) < (mode == 1 ? 25 : 70));
                end
            end
        end
    end

    // Compares each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result %h", $time, o_out_data);
            end else begin
                exp_r = pending_results.pop_front();
                if (exp_r.drive_x !== o_out_data.drive_x) begin
                    error_count++;
                    $display("%0t: drive_x expected %0d actual %0d", $time,
                             exp_r.drive_x, o_out_data.drive_x);
                end
                if (exp_r.damp_x !== o_out_data.damp_x) begin
                    error_count++;
                    $display("%0t: damp_x expected %0d actual %0d", $time,
                             exp_r.damp_x, o_out_data.damp_x);
                end
                if (exp_r.drive_y !== o_out_data.drive_y) begin
                    error_count++;
                    $display("%0t: drive_y expected %0d actual %0d", $time,
                             exp_r.drive_y, o_out_data.drive_y);
                end
                if (exp_r.damp_y !== o_out_data.damp_y) begin
                    error_count++;
                    $display("%0t: damp_y expected %0d actual %0d", $time,
                             exp_r.damp_y, o_out_data.damp_y);
                end
                if (exp_r.updated !== o_out_data.updated) begin
                    error_count++;
                    $display("%0t: updated expected %0b actual %0b", $time,
                             exp_r.updated, o_out_data.updated);
                end
            end
        end
    end

    // Run limit.
    initial begin
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        hold_request = 1'b0;
        stall_enable = 1'b0;
        error_count  = 0;
        ticks_sent   = 0;
        ticks_open   = 0;
        results_seen = 0;
        cfg_sets     = 0;
        filt_tc      = RST_FILTER_TIME;
        gain_reg     = '{RST_OUTER_P, RST_OUTER_I_X, RST_OUTER_I_Y, RST_OUTER_D,
                         RST_FORWARD, RST_INNER_P, RST_DAMPING};
        for (int k = 0; k < 2; k++) begin
            prev_err[k] = 0;
            rate_filt[k] = 0;
            integ_acc[k] = 0;
        end
        for (int k = 0; k < 4; k++) held_out[k] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        stall_enable = 1'b1;
        test_config_sweep();
        test_backpressure();
        test_random();
        repeat (50) @(posedge i_clk);

        $display("Covered %0d ticks (%0d with the gate open), %0d results, %0d register sets.",
                 ticks_sent, ticks_open, results_seen, cfg_sets);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
